FILE: hw/rtl/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// Types, constants and the quarter-cosine table for the vector direction core.
// ----------------------------------------------------------------------------
package vda_pkg;

	localparam logic [31:0] SAT_MIN    = 32'h8000_0000;
	localparam logic [31:0] SAT_VAL    = 32'h8000_0001;
	localparam logic [31:0] ONE_Q31    = 32'h7FFF_FFFF;
	localparam logic [31:0] POLY_C0    = 32'h0F5C_28F6;
	localparam logic [31:0] POLY_C1    = 32'h9992_2D0E;
	localparam logic [31:0] POLY_C2    = 32'h8B2A_3D71;
	localparam logic [31:0] ROUND_OFS  = 32'h007F_FFFF;
	localparam logic [6:0]  QUARTER    = 7'd64;
	localparam logic [7:0]  MASK_NEG_X = 8'h7F;
	localparam logic [7:0]  MASK_NEG_Y = 8'hFF;
	localparam logic [7:0]  MASK_SWAP  = 8'h3F;

	// folded vector and what it takes to unfold the angle
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [7:0]  mask;
		logic        zero;
	} vda_ctx_t;

	// upper 32 bits of an unsigned 32 x 32 product
	function automatic logic [31:0] hi32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b};
		return p[63:32];
	endfunction

	// magnitude with -2^31 saturated, sign in the top bit of the result
	function automatic logic [32:0] sat_mag(input logic [31:0] v);
		logic [31:0] s;
		s = (v == SAT_MIN) ? SAT_VAL : v;
		return s[31] ? {1'b1, 32'd0 - s} : {1'b0, s};
	endfunction

	// cos(i*pi/128) in q1.31, i = 0..64
	function automatic logic [31:0] quarter_cos(input logic [6:0] i);
		logic [31:0] c;
		case (i)
			7'd0:  c = 32'h80000000; 7'd1:  c = 32'h7FF62182;
			7'd2:  c = 32'h7FD8878E; 7'd3:  c = 32'h7FA736B4;
			7'd4:  c = 32'h7F62368F; 7'd5:  c = 32'h7F0991C4;
			7'd6:  c = 32'h7E9D55FC; 7'd7:  c = 32'h7E1D93EA;
			7'd8:  c = 32'h7D8A5F40; 7'd9:  c = 32'h7CE3CEB2;
			7'd10: c = 32'h7C29FBEE; 7'd11: c = 32'h7B5D039E;
			7'd12: c = 32'h7A7D055B; 7'd13: c = 32'h798A23B1;
			7'd14: c = 32'h78848414; 7'd15: c = 32'h776C4EDB;
			7'd16: c = 32'h7641AF3D; 7'd17: c = 32'h7504D345;
			7'd18: c = 32'h73B5EBD1; 7'd19: c = 32'h72552C85;
			7'd20: c = 32'h70E2CBC6; 7'd21: c = 32'h6F5F02B2;
			7'd22: c = 32'h6DCA0D14; 7'd23: c = 32'h6C242960;
			7'd24: c = 32'h6A6D98A4; 7'd25: c = 32'h68A69E81;
			7'd26: c = 32'h66CF8120; 7'd27: c = 32'h64E88926;
			7'd28: c = 32'h62F201AC; 7'd29: c = 32'h60EC3830;
			7'd30: c = 32'h5ED77C8A; 7'd31: c = 32'h5CB420E0;
			7'd32: c = 32'h5A82799A; 7'd33: c = 32'h5842DD54;
			7'd34: c = 32'h55F5A4D2; 7'd35: c = 32'h539B2AF0;
			7'd36: c = 32'h5133CC94; 7'd37: c = 32'h4EBFE8A5;
			7'd38: c = 32'h4C3FDFF4; 7'd39: c = 32'h49B41533;
			7'd40: c = 32'h471CECE7; 7'd41: c = 32'h447ACD50;
			7'd42: c = 32'h41CE1E65; 7'd43: c = 32'h3F1749B8;
			7'd44: c = 32'h3C56BA70; 7'd45: c = 32'h398CDD32;
			7'd46: c = 32'h36BA2014; 7'd47: c = 32'h33DEF287;
			7'd48: c = 32'h30FBC54D; 7'd49: c = 32'h2E110A62;
			7'd50: c = 32'h2B1F34EB; 7'd51: c = 32'h2826B928;
			7'd52: c = 32'h25280C5E; 7'd53: c = 32'h2223A4C5;
			7'd54: c = 32'h1F19F97B; 7'd55: c = 32'h1C0B826A;
			7'd56: c = 32'h18F8B83C; 7'd57: c = 32'h15E21445;
			7'd58: c = 32'h12C8106F; 7'd59: c = 32'h0FAB272B;
			7'd60: c = 32'h0C8BD35E; 7'd61: c = 32'h096A9049;
			7'd62: c = 32'h0647D97C; 7'd63: c = 32'h03242ABF;
			default: c = 32'h00000000;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/vector_direction_angle_core.sv
// ----------------------------------------------------------------------------
// vector_direction_angle_core
// Direction of a signed 32-bit vector as an 8-bit binary angle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one word (vec_x, vec_y), two's
//   complement. Output channel out_valid/out_ready carries direction, 256
//   steps per turn counterclockwise from +x, rounded down. A zero vector
//   gives 0, and -2^31 in either component is taken as -2^31+1.
//   The datapath is a ten-stage pipeline: fold, two normalize stages, four
//   multiply stages for the polynomial estimate, table lookup, the x*sin and
//   y*cos products, and the compare with unfold. Throughput is one word per
//   cycle while out_ready does not hold the pipeline, as every stage can take
//   a new word each cycle.
//   Each stage has its own valid bit and holds only while the stage after it
//   is full and stalled, so bubbles are squeezed out when out_ready is low
//   and in_ready stays high until all ten stages hold a word.
//   Reset clears all valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module vector_direction_angle_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] vec_x,
	input  logic [31:0] vec_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  direction
);
	import vda_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10;

	vda_ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8;
	logic [7:0]  mask_s9, mask_s10;
	logic        zero_s9;
	logic [31:0] p1_s4, p2_s4, t1_s5, t1_s6, m_s6, t2_s7;
	logic [6:0]  est_s8, est_s9;
	logic [31:0] csin_s8, ccos_s8;
	logic [63:0] xs_s9, yc_s9;
	logic [7:0]  dir_s10;

	// per-stage enables, a stage moves when it is empty or the next one moves
	assign en10 = !v_s10 || out_ready;
	assign en9  = !v_s9  || en10;
	assign en8  = !v_s8  || en9;
	assign en7  = !v_s7  || en8;
	assign en6  = !v_s6  || en7;
	assign en5  = !v_s5  || en6;
	assign en4  = !v_s4  || en5;
	assign en3  = !v_s3  || en4;
	assign en2  = !v_s2  || en3;
	assign en1  = !v_s1  || en2;
	assign in_ready  = en1;
	assign out_valid = v_s10;
	assign direction = dir_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else begin
			if (en1)  v_s1  <= in_valid;
			if (en2)  v_s2  <= v_s1;
			if (en3)  v_s3  <= v_s2;
			if (en4)  v_s4  <= v_s3;
			if (en5)  v_s5  <= v_s4;
			if (en6)  v_s6  <= v_s5;
			if (en7)  v_s7  <= v_s6;
			if (en8)  v_s8  <= v_s7;
			if (en9)  v_s9  <= v_s8;
			if (en10) v_s10 <= v_s9;
		end
	end

	// stage 1: magnitudes and fold into the first octant
	vda_ctx_t fold_c;
	logic [32:0] mx_c, my_c;
	always_comb begin
		mx_c = sat_mag(vec_x);
		my_c = sat_mag(vec_y);
		fold_c.mask = (mx_c[32] ? MASK_NEG_X : 8'h00) ^ (my_c[32] ? MASK_NEG_Y : 8'h00);
		if (my_c[31:0] > mx_c[31:0]) begin
			fold_c.x    = my_c[31:0];
			fold_c.y    = mx_c[31:0];
			fold_c.mask = fold_c.mask ^ MASK_SWAP;
		end else begin
			fold_c.x = mx_c[31:0];
			fold_c.y = my_c[31:0];
		end
		fold_c.zero = (fold_c.x == 32'd0);
	end

	// stage 2: coarse normalize by 16 and 8
	vda_ctx_t nrm2_c;
	always_comb begin
		nrm2_c = ctx_s1;
		if (nrm2_c.x[31:16] == 16'd0) begin
			nrm2_c.x = {nrm2_c.x[15:0], 16'd0};
			nrm2_c.y = {nrm2_c.y[15:0], 16'd0};
		end
		if (nrm2_c.x[31:24] == 8'd0) begin
			nrm2_c.x = {nrm2_c.x[23:0], 8'd0};
			nrm2_c.y = {nrm2_c.y[23:0], 8'd0};
		end
	end

	// stage 3: fine normalize by 4, 2 and 1
	vda_ctx_t nrm3_c;
	always_comb begin
		nrm3_c = ctx_s2;
		if (nrm3_c.x[31:28] == 4'd0) begin
			nrm3_c.x = {nrm3_c.x[27:0], 4'd0};
			nrm3_c.y = {nrm3_c.y[27:0], 4'd0};
		end
		if (nrm3_c.x[31:30] == 2'd0) begin
			nrm3_c.x = {nrm3_c.x[29:0], 2'd0};
			nrm3_c.y = {nrm3_c.y[29:0], 2'd0};
		end
		if (!nrm3_c.x[31]) begin
			nrm3_c.x = {nrm3_c.x[30:0], 1'b0};
			nrm3_c.y = {nrm3_c.y[30:0], 1'b0};
		end
	end

	// stage 8: round the estimate, clamp, read both table entries
	logic [31:0] rnd_c;
	logic [6:0]  est_c;
	always_comb begin
		rnd_c = t2_s7 + ROUND_OFS;
		est_c = (rnd_c[31:24] > {1'b0, QUARTER}) ? QUARTER : rnd_c[30:24];
	end

	// stage 10: one-step correction, unfold, tie break
	logic [7:0] res_c;
	always_comb begin
		res_c = {1'b0, est_s9};
		if (xs_s9 > yc_s9)
			res_c = res_c - 8'd1;
		res_c = res_c ^ mask_s9;
		if (xs_s9 == yc_s9)
			res_c = res_c + {7'd0, mask_s9[0]};
		if (zero_s9)
			res_c = 8'd0;
	end

	always_ff @(posedge clk) begin
		if (en1)
			ctx_s1 <= fold_c;
		if (en2)
			ctx_s2 <= nrm2_c;
		if (en3)
			ctx_s3 <= nrm3_c;
		if (en4) begin
			ctx_s4 <= ctx_s3;
			p1_s4  <= hi32(ONE_Q31 - ctx_s3.x, ctx_s3.x);
			p2_s4  <= hi32(ONE_Q31 - ctx_s3.x, ctx_s3.y);
		end
		if (en5) begin
			ctx_s5 <= ctx_s4;
			t1_s5  <= hi32(POLY_C0 - p1_s4, p2_s4);
		end
		if (en6) begin
			ctx_s6 <= ctx_s5;
			t1_s6  <= t1_s5;
			m_s6   <= hi32(POLY_C2, t1_s5);
		end
		if (en7) begin
			ctx_s7 <= ctx_s6;
			t2_s7  <= hi32(POLY_C1 - m_s6, t1_s6);
		end
		if (en8) begin
			ctx_s8  <= ctx_s7;
			est_s8  <= est_c;
			csin_s8 <= quarter_cos(QUARTER - est_c);
			ccos_s8 <= quarter_cos(est_c);
		end
		if (en9) begin
			xs_s9   <= {32'd0, ctx_s8.x} * {32'd0, csin_s8};
			yc_s9   <= {32'd0, ctx_s8.y} * {32'd0, ccos_s8};
			est_s9  <= est_s8;
			mask_s9 <= ctx_s8.mask;
			zero_s9 <= ctx_s8.zero;
		end
		if (en10) begin
			dir_s10  <= res_c;
			mask_s10 <= mask_s9;
		end
	end

	// folded vector always has x at least y
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (ctx_s1.x >= ctx_s1.y))
		else $error("fold left y above x");

	// normalized x has its top bit set unless the vector is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !ctx_s3.zero) |-> ctx_s3.x[31])
		else $error("normalize left x unnormalized");

	// a stalled product stage keeps its word
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s9 && !en9) |=> (v_s9 && $stable(xs_s9) && $stable(yc_s9)))
		else $error("product stage lost a word under stall");

	// a stalled output keeps the unfold mask of its word
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s10 && !out_ready) |=> $stable(mask_s10))
		else $error("output stage changed under stall");

endmodule
